/* rtl/core/least_loaded_server_selector_assert.svh */
// Assertion macros for the RTL of the server selector.
`ifndef LEAST_LOADED_SERVER_SELECTOR_ASSERT_SVH
`define LEAST_LOADED_SERVER_SELECTOR_ASSERT_SVH

`ifndef SYNTHESIS

`define LLSS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("llss assertion failed");

`define LLSS_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("llss forbidden condition seen");

`else

`define LLSS_ASSERT(lbl, clk, rst_n, prop)

`define LLSS_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* rtl/core/llss_pkg.sv */
`default_nettype none

package llss_pkg;

	localparam int MAX_SERVERS = 16;
	localparam int SLOT_W      = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

	localparam logic [1:0] MODE_UPDATE = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_SELECT = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [31:0] COUNT_BLOCKED = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] server_id;
		logic [31:0] new_count;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] chosen_id;
		logic [31:0] chosen_count;
	} rsp_t;

	typedef struct packed {
		logic [31:0] server_id;
		logic [31:0] count;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		entry_t            data;
		logic              set_valid;
		logic              clr_valid;
	} wr_req_t;

endpackage

`default_nettype wire

/* rtl/core/llss_store.sv */
`default_nettype none

module llss_store (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             rd_en,
	input  wire logic [llss_pkg::SLOT_W-1:0]      rd_addr,
	output      llss_pkg::entry_t                 rd_data,
	output      logic [llss_pkg::MAX_SERVERS-1:0] valid,
	input  wire llss_pkg::wr_req_t                wr
);
	import llss_pkg::*;

	entry_t mem [MAX_SERVERS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= '0;
		end else if (wr.set_valid) begin
			valid[wr.addr] <= 1'b1;
		end else if (wr.clr_valid) begin
			valid[wr.addr] <= 1'b0;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/least_loaded_server_selector.sv */
// Channel   Direction  Handshake                 Beat
// request   in         start high, busy low      req   (mode, server_id, new_count)
// result    out        done strobe, one cycle    rsp   (status, chosen_id, chosen_count)
//
// Every request runs a scan over the slot memory, one read a cycle through its single
// read port, then passes the drain and finish states before the result strobe.
// Busy is high from the cycle after acceptance until the result strobe rises, so the
// next request can be accepted at the edge that ends the strobe.
// Reset clears the valid bits and the controller; slot contents stay as they were.
// The receiver cannot stall, so each result beat is present for exactly one cycle.
`default_nettype none

module least_loaded_server_selector (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output      logic           busy,
	input  wire llss_pkg::req_t req,
	output      logic           done,
	output      llss_pkg::rsp_t rsp
);
	import llss_pkg::*;

`include "least_loaded_server_selector_assert.svh"

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_SERVERS - 1);

	state_t                  state_q;
	logic [SLOT_W-1:0]       addr_q;
	logic                    rd_s1;
	logic [SLOT_W-1:0]       idx_s1;
	req_t                    req_q;

	logic                    find_hit_q;
	logic [SLOT_W-1:0]       find_slot_q;
	logic [31:0]             find_count_q;
	logic                    free_hit_q;
	logic [SLOT_W-1:0]       free_slot_q;
	logic                    best_hit_q;
	logic [SLOT_W-1:0]       best_slot_q;
	logic [31:0]             best_count_q;
	logic [31:0]             best_id_q;

	entry_t                  rd_data;
	logic [MAX_SERVERS-1:0]  valid_vec;
	wr_req_t                 wr;
	rsp_t                    rsp_d;
	logic                    accept;
	logic                    slot_v;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign slot_v = valid_vec[idx_s1];

	llss_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (state_q == S_SCAN),
		.rd_addr (addr_q),
		.rd_data (rd_data),
		.valid   (valid_vec),
		.wr      (wr)
	);

	always_comb begin
		wr              = '0;
		rsp_d.status    = ST_MISS;
		rsp_d.chosen_id = req_q.server_id;
		rsp_d.chosen_count = '0;
		case (req_q.mode)
			MODE_UPDATE: begin
				if (find_hit_q) begin
					wr.en   = 1'b1;
					wr.addr = find_slot_q;
				end else if (free_hit_q) begin
					wr.en        = 1'b1;
					wr.addr      = free_slot_q;
					wr.set_valid = 1'b1;
				end
				wr.data.server_id = req_q.server_id;
				wr.data.count     = req_q.new_count;
				if (find_hit_q || free_hit_q) begin
					rsp_d.status       = ST_OK;
					rsp_d.chosen_count = req_q.new_count;
				end else begin
					rsp_d.status = ST_FULL;
				end
			end
			MODE_REMOVE: begin
				if (find_hit_q) begin
					wr.addr            = find_slot_q;
					wr.clr_valid       = 1'b1;
					rsp_d.status       = ST_OK;
					rsp_d.chosen_count = find_count_q;
				end
			end
			MODE_SELECT: begin
				wr.addr           = best_slot_q;
				wr.data.server_id = best_id_q;
				wr.data.count     = best_count_q + 32'd1;
				if (best_hit_q) begin
					wr.en              = 1'b1;
					rsp_d.status       = ST_OK;
					rsp_d.chosen_id    = best_id_q;
					rsp_d.chosen_count = best_count_q + 32'd1;
				end else begin
					rsp_d.chosen_id = '0;
				end
			end
			default: begin
			end
		endcase
		if (state_q != S_FINISH) begin
			wr.en        = 1'b0;
			wr.set_valid = 1'b0;
			wr.clr_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			addr_q  <= '0;
			rd_s1   <= 1'b0;
			done    <= 1'b0;
			rsp     <= '0;
		end else begin
			done  <= 1'b0;
			rd_s1 <= (state_q == S_SCAN);
			case (state_q)
				S_IDLE: begin
					addr_q <= '0;
					if (accept) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					addr_q <= addr_q + SLOT_W'(1);
					if (addr_q == LAST_SLOT) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					done    <= 1'b1;
					rsp     <= rsp_d;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (accept) begin
			req_q        <= req;
			find_hit_q   <= 1'b0;
			free_hit_q   <= 1'b0;
			best_hit_q   <= 1'b0;
			best_count_q <= COUNT_BLOCKED;
		end else if (rd_s1) begin
			if (slot_v && !find_hit_q && rd_data.server_id == req_q.server_id) begin
				find_hit_q   <= 1'b1;
				find_slot_q  <= idx_s1;
				find_count_q <= rd_data.count;
			end
			if (!slot_v && !free_hit_q) begin
				free_hit_q  <= 1'b1;
				free_slot_q <= idx_s1;
			end
			if (slot_v && rd_data.count < best_count_q) begin
				best_hit_q   <= 1'b1;
				best_slot_q  <= idx_s1;
				best_count_q <= rd_data.count;
				best_id_q    <= rd_data.server_id;
			end
		end
	end

	`LLSS_ASSERT(a_accept_busy, clk, arst_n, accept |=> busy)
	`LLSS_ASSERT(a_done_idle, clk, arst_n, done |-> (state_q == S_IDLE))
	`LLSS_NEVER(a_write_outside_finish, clk, arst_n,
		(wr.en || wr.set_valid || wr.clr_valid) && (state_q != S_FINISH))
	`LLSS_NEVER(a_read_return_late, clk, arst_n,
		rd_s1 && (state_q == S_IDLE || state_q == S_FINISH))

endmodule

`default_nettype wire
